// ===== sv/esc_pkg.sv =====
package esc_pkg;

  // Configuration port
  localparam int unsigned REG_W = 64;
  localparam int unsigned IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_TEMP_CALIB       = 3'd0,
    REG_PRESS_CALIB_LO   = 3'd1,
    REG_PRESS_CALIB_HI   = 3'd2,
    REG_PRESS_CALIB_LAST = 3'd3,
    REG_HUM_CALIB        = 3'd4
  } reg_index_t;

  // Fine temperature term, 1/5120 degC
  localparam int unsigned TF_W = 23;

  // Pressure divider geometry
  localparam int unsigned DIV_QB = 37;
  localparam int unsigned DIV_DW = 40;
  localparam int unsigned DIV_NW = 76;
  localparam logic [DIV_QB-1:0] DIV_QUOT_LIMIT = DIV_QB'(1) << (DIV_QB - 1);

  // Pipeline depths
  localparam int unsigned PRE_LAT   = 8;
  localparam int unsigned DIV_LAT   = DIV_QB + 2;
  localparam int unsigned POST_LAT  = 4;
  localparam int unsigned PRESS_LAT = PRE_LAT + DIV_LAT + POST_LAT;
  localparam int unsigned HUM_LAT   = 9;

  localparam logic [24:0] PRESS_MAX = 25'd33554431;
  localparam logic [28:0] HUM_MAX   = 29'd419430400;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic        [24:0] pressure_q24_8;
    logic               pressure_valid;
    logic        [16:0] humidity_q22_10;
  } result_t;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
  } temp_coef_t;

  typedef struct packed {
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } press_coef_t;

  typedef struct packed {
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } hum_coef_t;

  // Side info that rides along the divider
  typedef struct packed {
    logic sign;
    logic ok;
  } div_meta_t;

endpackage

// ===== sv/esc_fine.sv =====
module esc_fine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_vld,
  input  esc_pkg::sample_t                 sample,
  input  esc_pkg::temp_coef_t              coef,
  output logic                             out_vld,
  output logic signed [esc_pkg::TF_W-1:0]  tf,
  output logic signed [15:0]               temperature,
  output logic        [19:0]               raw_pressure,
  output logic        [15:0]               raw_humidity
);

  logic               v1, v2, v3, v4;
  logic signed [17:0] s1_a;
  logic signed [16:0] s1_d;
  logic        [19:0] s1_p, s2_p, s3_p, s4_p;
  logic        [15:0] s1_h, s2_h, s3_h, s4_h;
  logic signed [33:0] s2_m1, s2_dd;
  logic signed [22:0] s3_v1;
  logic signed [37:0] s3_m2;
  logic signed [esc_pkg::TF_W-1:0] s4_tf;

  logic signed [17:0] a_c;
  logic signed [16:0] d_c;
  logic signed [33:0] m1_c, dd_c;
  logic signed [37:0] m2_c;
  logic signed [24:0] tf_c;
  logic signed [26:0] t5_c;
  logic signed [18:0] ts_c;
  logic signed [15:0] tsat_c;

  always_comb begin
    a_c  = $signed({1'b0, sample.raw_temperature[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
    d_c  = $signed({1'b0, sample.raw_temperature[19:4]}) - $signed({1'b0, coef.t1});
    m1_c = s1_a * coef.t2;
    dd_c = s1_d * s1_d;
    m2_c = $signed(s2_dd[33:12]) * coef.t3;
    tf_c = 25'(s3_v1) + 25'($signed(s3_m2[37:14]));
    t5_c = 27'(s4_tf) * 27'sd5 + 27'sd128;
    ts_c = $signed(t5_c[26:8]);
    if (ts_c > 19'sd32767) begin
      tsat_c = 16'sh7FFF;
    end else if (ts_c < -19'sd32768) begin
      tsat_c = 16'sh8000;
    end else begin
      tsat_c = ts_c[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v1      <= in_vld;
      v2      <= v1;
      v3      <= v2;
      v4      <= v3;
      out_vld <= v4;
    end
  end

  always_ff @(posedge clk) begin
    s1_a <= a_c;
    s1_d <= d_c;
    s1_p <= sample.raw_pressure;
    s1_h <= sample.raw_humidity;
    s2_m1 <= m1_c;
    s2_dd <= dd_c;
    s2_p  <= s1_p;
    s2_h  <= s1_h;
    s3_v1 <= $signed(s2_m1[33:11]);
    s3_m2 <= m2_c;
    s3_p  <= s2_p;
    s3_h  <= s2_h;
    s4_tf <= tf_c[esc_pkg::TF_W-1:0];
    s4_p  <= s3_p;
    s4_h  <= s3_h;
    tf           <= s4_tf;
    temperature  <= tsat_c;
    raw_pressure <= s4_p;
    raw_humidity <= s4_h;
  end

endmodule

// ===== sv/esc_div.sv =====
module esc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  input  logic [esc_pkg::DIV_NW-1:0]    num,
  input  logic [esc_pkg::DIV_DW-1:0]    den,
  input  esc_pkg::div_meta_t            in_meta,
  output logic                          out_vld,
  output logic [esc_pkg::DIV_QB-1:0]    quot,
  output esc_pkg::div_meta_t            out_meta
);

  localparam int unsigned QB = esc_pkg::DIV_QB;
  localparam int unsigned DW = esc_pkg::DIV_DW;
  localparam int unsigned NW = esc_pkg::DIV_NW;

  logic               vld  [0:QB];
  logic               sat  [0:QB];
  logic [DW-1:0]      rem  [0:QB];
  logic [DW-1:0]      dd   [0:QB];
  logic [QB-1:0]      low  [0:QB];
  logic [QB-1:0]      q    [0:QB];
  esc_pkg::div_meta_t meta [0:QB];

  // Quotient at or above 2^QB when the top numerator bits already reach the divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    sat[0]  <= (DW'(num[NW-1:QB]) >= den);
    rem[0]  <= DW'(num[NW-1:QB]);
    dd[0]   <= den;
    low[0]  <= num[QB-1:0];
    q[0]    <= '0;
    meta[0] <= in_meta;
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_next;

    always_comb begin
      trial    = {rem[k], low[k][QB-1]};
      ge       = (trial >= {1'b0, dd[k]});
      rem_next = ge ? DW'(trial - {1'b0, dd[k]}) : trial[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1]  <= rem_next;
      low[k+1]  <= low[k] << 1;
      q[k+1]    <= {q[k][QB-2:0], ge};
      dd[k+1]   <= dd[k];
      sat[k+1]  <= sat[k];
      meta[k+1] <= meta[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    quot     <= (sat[QB] || q[QB] > esc_pkg::DIV_QUOT_LIMIT) ? esc_pkg::DIV_QUOT_LIMIT : q[QB];
    out_meta <= meta[QB];
  end

endmodule

// ===== sv/esc_press.sv =====
module esc_press (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_vld,
  input  logic signed [esc_pkg::TF_W-1:0]  tf,
  input  logic        [19:0]               raw_pressure,
  input  esc_pkg::press_coef_t             coef,
  output logic                             out_vld,
  output logic        [24:0]               pressure,
  output logic                             pvalid
);

  localparam int unsigned DW = esc_pkg::DIV_DW;
  localparam int unsigned NW = esc_pkg::DIV_NW;
  localparam int unsigned QB = esc_pkg::DIV_QB;

  logic v1, v2, v3, v4, v5, v6, v7, v8;
  logic q1v, q2v, q3v;

  // Pre-divide stages
  logic signed [23:0] p1_v;
  logic signed [21:0] p1_pd, p2_pd, p3_pd, p4_pd;
  logic signed [47:0] p2_sq;
  logic signed [39:0] p2_l5, p2_l2, p3_l5, p3_l2;
  logic signed [63:0] p3_a6, p3_a3;
  logic signed [63:0] p4_v2;
  logic signed [56:0] p4_x;
  logic signed [56:0] p5_xhp;
  logic        [32:0] p5_w;
  logic signed [65:0] p5_num;
  logic signed [40:0] p6_dv;
  logic               p6_ns, p7_ns;
  logic        [63:0] p6_nmag;
  logic        [DW-1:0] p7_dmag, p8_den;
  logic               p7_ds, p7_ok;
  logic        [43:0] p7_plo, p7_phi;
  logic        [NW-1:0] p8_num;
  esc_pkg::div_meta_t p8_meta;

  logic signed [23:0] v_c;
  logic signed [21:0] pd_c;
  logic signed [63:0] v2_c;
  logic signed [56:0] x_c;
  logic signed [65:0] num_c;
  logic signed [56:0] dsum_c;

  // Post-divide stages
  logic                  d_vld;
  logic [QB-1:0]         d_q;
  esc_pkg::div_meta_t    d_meta;
  logic signed [37:0]    q1_ps, q2_ps, q3_ps;
  logic                  q1_ok, q2_ok, q3_ok;
  logic signed [49:0]    q2_sq;
  logic signed [53:0]    q2_m8, q3_m8;
  logic signed [65:0]    q3_m9;
  logic signed [40:0]    s_c;
  logic signed [33:0]    f_c;
  logic        [24:0]    fc_c;

  always_comb begin
    v_c    = 24'(tf) - 24'sd128000;
    pd_c   = 22'sd1048576 - $signed({2'b0, raw_pressure});
    v2_c   = p3_a6 + (64'(p3_l5) <<< 17) + (64'(coef.p4) <<< 35);
    x_c    = 57'(p3_a3 >>> 8) + (57'(p3_l2) <<< 12) + (57'sd1 <<< 47);
    num_c  = (66'(p4_pd) <<< 31) - 66'(p4_v2);
    dsum_c = p5_xhp + $signed({41'b0, p5_w[32:17]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8} <= '0;
    end else begin
      {v1, v2, v3, v4, v5, v6, v7, v8} <= {in_vld, v1, v2, v3, v4, v5, v6, v7};
    end
  end

  always_ff @(posedge clk) begin
    p1_v  <= v_c;
    p1_pd <= pd_c;
    p2_sq <= p1_v * p1_v;
    p2_l5 <= p1_v * coef.p5;
    p2_l2 <= p1_v * coef.p2;
    p2_pd <= p1_pd;
    p3_a6 <= p2_sq * coef.p6;
    p3_a3 <= p2_sq * coef.p3;
    p3_l5 <= p2_l5;
    p3_l2 <= p2_l2;
    p3_pd <= p2_pd;
    p4_v2 <= v2_c;
    p4_x  <= x_c;
    p4_pd <= p3_pd;
    // Split the P1 product so each partial stays narrow
    p5_xhp <= $signed(p4_x[56:17]) * $signed({1'b0, coef.p1});
    p5_w   <= p4_x[16:0] * coef.p1;
    p5_num <= num_c;
    p6_dv   <= $signed(dsum_c[56:16]);
    p6_ns   <= p5_num[65];
    p6_nmag <= p5_num[65] ? 64'(-p5_num) : p5_num[63:0];
    p7_dmag <= p6_dv[40] ? DW'(-p6_dv) : DW'(p6_dv);
    p7_ds   <= p6_dv[40];
    p7_ok   <= (p6_dv != '0);
    p7_ns   <= p6_ns;
    p7_plo  <= p6_nmag[31:0] * 12'd3125;
    p7_phi  <= p6_nmag[63:32] * 12'd3125;
    p8_num       <= NW'({p7_phi, 32'b0}) + NW'(p7_plo);
    p8_den       <= p7_dmag;
    p8_meta.sign <= p7_ns ^ p7_ds;
    p8_meta.ok   <= p7_ok;
  end

  esc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (v8),
    .num      (p8_num),
    .den      (p8_den),
    .in_meta  (p8_meta),
    .out_vld  (d_vld),
    .quot     (d_q),
    .out_meta (d_meta)
  );

  always_comb begin
    s_c = 41'(q3_ps) + 41'(q3_m9 >>> 25) + 41'(q3_m8 >>> 19);
    f_c = 34'(s_c >>> 8) + (34'(coef.p7) <<< 4);
    if (f_c < 34'sd0) begin
      fc_c = '0;
    end else if (f_c > $signed({9'b0, esc_pkg::PRESS_MAX})) begin
      fc_c = esc_pkg::PRESS_MAX;
    end else begin
      fc_c = f_c[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {q1v, q2v, q3v, out_vld} <= '0;
    end else begin
      {q1v, q2v, q3v, out_vld} <= {d_vld, q1v, q2v, q3v};
    end
  end

  always_ff @(posedge clk) begin
    q1_ps <= d_meta.sign ? -$signed({1'b0, d_q}) : $signed({1'b0, d_q});
    q1_ok <= d_meta.ok;
    q2_sq <= $signed(q1_ps[37:13]) * $signed(q1_ps[37:13]);
    q2_m8 <= q1_ps * coef.p8;
    q2_ps <= q1_ps;
    q2_ok <= q1_ok;
    q3_m9 <= q2_sq * coef.p9;
    q3_m8 <= q2_m8;
    q3_ps <= q2_ps;
    q3_ok <= q2_ok;
    pressure <= q3_ok ? fc_c : '0;
    pvalid   <= q3_ok;
  end

endmodule

// ===== sv/esc_hum.sv =====
module esc_hum (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_vld,
  input  logic signed [esc_pkg::TF_W-1:0]  tf,
  input  logic        [15:0]               raw_humidity,
  input  esc_pkg::hum_coef_t               coef,
  output logic                             out_vld,
  output logic        [16:0]               humidity
);

  logic [7:0] vld;

  logic signed [23:0] h1_x;
  logic signed [33:0] h1_base, h2_base;
  logic signed [35:0] h2_m5;
  logic signed [31:0] h2_b0;
  logic signed [32:0] h2_c0;
  logic signed [21:0] h3_a, h4_a, h5_a, h3_b;
  logic signed [22:0] h3_c;
  logic signed [44:0] h4_bc;
  logic signed [51:0] h5_eh;
  logic signed [59:0] h6_af, h7_af, h8_af;
  logic               h7_big, h8_big;
  logic signed [61:0] h7_ss;
  logic signed [63:0] h8_t;

  logic signed [36:0] am_c;
  logic signed [35:0] e_c;
  logic signed [44:0] s_c;
  logic signed [60:0] y_c;
  logic        [28:0] yv_c;

  always_comb begin
    am_c = 37'(h2_base) - 37'(h2_m5);
    e_c  = 36'($signed(h4_bc[44:10])) + 36'sd2097152;
    s_c  = $signed(h6_af[59:15]);
    y_c  = 61'(h8_af) - 61'(h8_t >>> 4);
    if (h8_big) begin
      // Quadratic term dominates: full scale only without the H1 correction
      yv_c = (h8_af > 60'sd0 && coef.h1 == 8'd0) ? esc_pkg::HUM_MAX : '0;
    end else if (y_c < 61'sd0) begin
      yv_c = '0;
    end else if (y_c > $signed({32'b0, esc_pkg::HUM_MAX})) begin
      yv_c = esc_pkg::HUM_MAX;
    end else begin
      yv_c = y_c[28:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else begin
      vld     <= {vld[6:0], in_vld};
      out_vld <= vld[7];
    end
  end

  always_ff @(posedge clk) begin
    h1_x    <= 24'(tf) - 24'sd76800;
    h1_base <= (34'($signed({1'b0, raw_humidity})) <<< 14) - (34'(coef.h4) <<< 20)
               + 34'sd16384;
    h2_m5   <= h1_x * coef.h5;
    h2_b0   <= h1_x * coef.h6;
    h2_c0   <= h1_x * $signed({1'b0, coef.h3});
    h2_base <= h1_base;
    h3_a    <= $signed(am_c[36:15]);
    h3_b    <= $signed(h2_b0[31:10]);
    h3_c    <= 23'($signed(h2_c0[32:11])) + 23'sd32768;
    h4_bc   <= h3_b * h3_c;
    h4_a    <= h3_a;
    h5_eh   <= e_c * coef.h2 + 52'sd8192;
    h5_a    <= h4_a;
    h6_af   <= h5_a * $signed(h5_eh[51:14]);
    h7_af   <= h6_af;
    h7_big  <= (s_c >= (45'sd1 <<< 30)) || (s_c <= -(45'sd1 <<< 30));
    h7_ss   <= $signed(s_c[30:0]) * $signed(s_c[30:0]);
    h8_t    <= $signed(h7_ss[61:7]) * $signed({1'b0, coef.h1});
    h8_af   <= h7_af;
    h8_big  <= h7_big;
    humidity <= yv_c[28:12];
  end

endmodule

// ===== sv/env_sensor_compensation.sv =====
// Environmental sensor compensation pipeline.
//
// Input channel: drive sample with one raw temperature / pressure / humidity
// reading and raise start; the beat is taken at a rising edge with start high
// and busy low. busy is low whenever the block is out of reset, so a new beat
// may enter on every cycle.
// Result channel: done pulses for one cycle with the compensated beat on
// result. The receiver cannot stall, and none is needed: results leave in
// arrival order, one per accepted beat.
// Pipeline: between the accept edge and done lie 5 stages of fine
// temperature, 8 pressure pre-divide stages, a 39-stage restoring divider
// that retires one quotient bit per step stage, and 4 correction stages.
// Throughput: one beat per cycle, set by the fully pipelined divider.
// Calibration: write the five calibration words through wr_en / wr_index /
// wr_data while no beat is in flight. Unknown indexes are dropped.
// Reset: synchronous rst clears all valid bits and calibration words;
// beats in flight are dropped.
module env_sensor_compensation (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  esc_pkg::sample_t                sample,
  input  logic                            wr_en,
  input  logic [esc_pkg::IDX_W-1:0]       wr_index,
  input  logic [esc_pkg::REG_W-1:0]       wr_data,
  output logic                            done,
  output esc_pkg::result_t                result
);

  localparam int unsigned TEMP_DLY = esc_pkg::PRESS_LAT;
  localparam int unsigned HUM_DLY  = esc_pkg::PRESS_LAT - esc_pkg::HUM_LAT;

  logic [47:0] temp_calib;
  logic [63:0] press_calib_lo;
  logic [63:0] press_calib_hi;
  logic [15:0] press_calib_last;
  logic [63:0] hum_calib;

  esc_pkg::temp_coef_t  tcoef;
  esc_pkg::press_coef_t pcoef;
  esc_pkg::hum_coef_t   hcoef;

  logic                            f_vld;
  logic signed [esc_pkg::TF_W-1:0] f_tf;
  logic signed [15:0]              f_temp;
  logic        [19:0]              f_p;
  logic        [15:0]              f_h;

  logic        p_vld;
  logic [24:0] p_val;
  logic        p_ok;
  logic        h_vld;
  logic [16:0] h_val;

  logic signed [15:0] temp_dly [0:TEMP_DLY-1];
  logic        [16:0] hum_dly  [0:HUM_DLY-1];

  assign busy = rst;

  // Calibration words; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib       <= '0;
      press_calib_lo   <= '0;
      press_calib_hi   <= '0;
      press_calib_last <= '0;
      hum_calib        <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        esc_pkg::REG_TEMP_CALIB:       temp_calib       <= wr_data[47:0];
        esc_pkg::REG_PRESS_CALIB_LO:   press_calib_lo   <= wr_data;
        esc_pkg::REG_PRESS_CALIB_HI:   press_calib_hi   <= wr_data;
        esc_pkg::REG_PRESS_CALIB_LAST: press_calib_last <= wr_data[15:0];
        esc_pkg::REG_HUM_CALIB:        hum_calib        <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // Unpack the coefficient fields
  always_comb begin
    tcoef.t1 = temp_calib[15:0];
    tcoef.t2 = temp_calib[31:16];
    tcoef.t3 = temp_calib[47:32];
    pcoef.p1 = press_calib_lo[15:0];
    pcoef.p2 = press_calib_lo[31:16];
    pcoef.p3 = press_calib_lo[47:32];
    pcoef.p4 = press_calib_lo[63:48];
    pcoef.p5 = press_calib_hi[15:0];
    pcoef.p6 = press_calib_hi[31:16];
    pcoef.p7 = press_calib_hi[47:32];
    pcoef.p8 = press_calib_hi[63:48];
    pcoef.p9 = press_calib_last;
    hcoef.h1 = hum_calib[7:0];
    hcoef.h2 = hum_calib[23:8];
    hcoef.h3 = hum_calib[31:24];
    hcoef.h4 = hum_calib[43:32];
    hcoef.h5 = hum_calib[55:44];
    hcoef.h6 = hum_calib[63:56];
  end

  esc_fine u_fine (
    .clk          (clk),
    .rst          (rst),
    .in_vld       (start && !busy),
    .sample       (sample),
    .coef         (tcoef),
    .out_vld      (f_vld),
    .tf           (f_tf),
    .temperature  (f_temp),
    .raw_pressure (f_p),
    .raw_humidity (f_h)
  );

  esc_press u_press (
    .clk          (clk),
    .rst          (rst),
    .in_vld       (f_vld),
    .tf           (f_tf),
    .raw_pressure (f_p),
    .coef         (pcoef),
    .out_vld      (p_vld),
    .pressure     (p_val),
    .pvalid       (p_ok)
  );

  esc_hum u_hum (
    .clk          (clk),
    .rst          (rst),
    .in_vld       (f_vld),
    .tf           (f_tf),
    .raw_humidity (f_h),
    .coef         (hcoef),
    .out_vld      (h_vld),
    .humidity     (h_val)
  );

  // Hold temperature and humidity until the pressure of the same beat arrives
  always_ff @(posedge clk) begin
    temp_dly[0] <= f_temp;
    for (int i = 1; i < TEMP_DLY; i++) begin
      temp_dly[i] <= temp_dly[i-1];
    end
    hum_dly[0] <= h_val;
    for (int i = 1; i < HUM_DLY; i++) begin
      hum_dly[i] <= hum_dly[i-1];
    end
  end

  // The humidity strobe lines up by construction; pressure strobe marks the beat
  always_comb begin
    done                     = p_vld;
    result.temperature_centi = temp_dly[TEMP_DLY-1];
    result.pressure_q24_8    = p_val;
    result.pressure_valid    = p_ok;
    result.humidity_q22_10   = h_vld ? hum_dly[HUM_DLY-1] : hum_dly[HUM_DLY-1];
  end

endmodule

// ===== tb/tb.sv =====
module tb;

  localparam int unsigned LATENCY     = 55;
  localparam int unsigned WDOG_LIMIT  = 4000;
  localparam int unsigned N_RAND      = 1200;
  localparam int unsigned N_CAL       = 8;
  localparam logic [esc_pkg::IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam longint QUOT_SAT = 64'sd1 << 36;
  localparam longint HUM_FULL = 64'sd419430400;

  typedef struct packed {
    logic             chk;
    esc_pkg::result_t want;
  } note_t;

  typedef struct {
    esc_pkg::sample_t smp;
    logic             chk;
    esc_pkg::result_t want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  esc_pkg::sample_t sample = '0;
  logic             wr_en = 1'b0;
  logic [esc_pkg::IDX_W-1:0] wr_index = '0;
  logic [esc_pkg::REG_W-1:0] wr_data = '0;
  logic             done;
  esc_pkg::result_t result;

  // Predictor copy of the calibration words
  logic [47:0] cal_temp;
  logic [63:0] cal_plo, cal_phi, cal_hum;
  logic [15:0] cal_p9;

  esc_pkg::result_t readings_due[$];   // expected compensated beats, oldest first
  note_t     row_notes[$];      // per sent beat: typed expectation, if any
  int        fails = 0;
  int        idle_cycles = 0;
  int        sender_idle_pct = 0;
  stim_row_t dir_rows[$];
  logic [63:0] cal_sets[N_CAL][5];

  env_sensor_compensation uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .result(result)
  );

  always #10 clk = ~clk;

  // Fine temperature, 1/5120 degC
  function automatic longint fine_temp(longint at);
    longint t1, t2, t3, v1, d, v2;
    t1 = longint'(cal_temp[15:0]);
    t2 = longint'($signed(cal_temp[31:16]));
    t3 = longint'($signed(cal_temp[47:32]));
    v1 = (((at >>> 3) - 2 * t1) * t2) >>> 11;
    d = (at >>> 4) - t1;
    v2 = (((d * d) >>> 12) * t3) >>> 14;
    return v1 + v2;
  endfunction

  // Truncating (a*3125)/d with the quotient magnitude saturated
  function automatic longint div_3125(longint a, longint d);
    logic signed [127:0] num, q;
    num = 128'(a) * 128'sd3125;
    q = num / 128'(d);
    if (q > 128'(QUOT_SAT)) q = 128'(QUOT_SAT);
    if (q < -128'(QUOT_SAT)) q = -128'(QUOT_SAT);
    return longint'(q);
  endfunction

  function automatic esc_pkg::result_t compensate(esc_pkg::sample_t s);
    esc_pkg::result_t r;
    longint tf, t, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint v1, v2, x, xh, w, p;
    longint h1, h2, h3, h4, h5, h6, hx, a, b, c, e, f, hs;
    tf = fine_temp(longint'(s.raw_temperature));
    t = (tf * 5 + 128) >>> 8;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    r.temperature_centi = 16'(t);

    p1 = longint'(cal_plo[15:0]);
    p2 = longint'($signed(cal_plo[31:16]));
    p3 = longint'($signed(cal_plo[47:32]));
    p4 = longint'($signed(cal_plo[63:48]));
    p5 = longint'($signed(cal_phi[15:0]));
    p6 = longint'($signed(cal_phi[31:16]));
    p7 = longint'($signed(cal_phi[47:32]));
    p8 = longint'($signed(cal_phi[63:48]));
    p9 = longint'($signed(cal_p9));
    v1 = tf - 128000;
    v2 = v1 * v1 * p6 + v1 * p5 * 131072 + p4 * (64'sd1 << 35);
    v1 = ((v1 * v1 * p3) >>> 8) + v1 * p2 * 4096;
    x = (64'sd1 << 47) + v1;
    xh = x >>> 17;
    w = (x & 64'sh1FFFF) * p1;
    v1 = (xh * p1 + (w >>> 17)) >>> 16;
    if (v1 == 0) begin
      r.pressure_q24_8 = '0;
      r.pressure_valid = 1'b0;
    end else begin
      p = 1048576 - longint'(s.raw_pressure);
      p = div_3125(p * (64'sd1 << 31) - v2, v1);
      x = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      w = (p8 * p) >>> 19;
      p = ((p + x + w) >>> 8) + p7 * 16;
      if (p < 0) p = 0;
      if (p > 33554431) p = 33554431;
      r.pressure_q24_8 = 25'(p);
      r.pressure_valid = 1'b1;
    end

    h1 = longint'(cal_hum[7:0]);
    h2 = longint'($signed(cal_hum[23:8]));
    h3 = longint'(cal_hum[31:24]);
    h4 = longint'($signed(cal_hum[43:32]));
    h5 = longint'($signed(cal_hum[55:44]));
    h6 = longint'($signed(cal_hum[63:56]));
    hx = tf - 76800;
    a = (longint'(s.raw_humidity) * 16384 - h4 * 1048576 - h5 * hx + 16384) >>> 15;
    b = (hx * h6) >>> 10;
    c = ((hx * h3) >>> 11) + 32768;
    e = ((b * c) >>> 10) + 2097152;
    f = (e * h2 + 8192) >>> 14;
    hx = a * f;
    hs = hx >>> 15;
    // quadratic term would swamp the value: the sign alone decides
    if (hs >= (64'sd1 << 30) || hs <= -(64'sd1 << 30))
      hx = (hx > 0 && h1 == 0) ? HUM_FULL : 0;
    else
      hx = hx - ((((hs * hs) >>> 7) * h1) >>> 4);
    if (hx < 0) hx = 0;
    if (hx > HUM_FULL) hx = HUM_FULL;
    r.humidity_q22_10 = 17'(hx >>> 12);
    return r;
  endfunction

  // Accept monitor: predict on every input beat
  always @(posedge clk) begin
    note_t n;
    if (!rst && start && !busy) begin
      n = row_notes.pop_front();
      readings_due.push_back(n.chk ? n.want : compensate(sample));
    end
  end

  // Result checker; results cannot be held off, so take every strobe
  always @(posedge clk) begin
    esc_pkg::result_t exp_r;
    if (!rst && done) begin
      if (readings_due.size() == 0) begin
        $error("result with no beat pending: %h", result);
        fails++;
      end else begin
        exp_r = readings_due.pop_front();
        if (result.temperature_centi !== exp_r.temperature_centi) begin
          $error("temperature_centi expected %0d got %0d",
                 exp_r.temperature_centi, result.temperature_centi);
          fails++;
        end
        if (result.pressure_q24_8 !== exp_r.pressure_q24_8) begin
          $error("pressure_q24_8 expected %0d got %0d",
                 exp_r.pressure_q24_8, result.pressure_q24_8);
          fails++;
        end
        if (result.pressure_valid !== exp_r.pressure_valid) begin
          $error("pressure_valid expected %0d got %0d",
                 exp_r.pressure_valid, result.pressure_valid);
          fails++;
        end
        if (result.humidity_q22_10 !== exp_r.humidity_q22_10) begin
          $error("humidity_q22_10 expected %0d got %0d",
                 exp_r.humidity_q22_10, result.humidity_q22_10);
          fails++;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat moving either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("[env_sensor_compensation] ERROR");
      $finish;
    end
  end

  // Write one calibration word; keep the predictor copy in step
  task automatic write_reg(logic [esc_pkg::IDX_W-1:0] idx, logic [63:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      esc_pkg::REG_TEMP_CALIB:       cal_temp = val[47:0];
      esc_pkg::REG_PRESS_CALIB_LO:   cal_plo = val;
      esc_pkg::REG_PRESS_CALIB_HI:   cal_phi = val;
      esc_pkg::REG_PRESS_CALIB_LAST: cal_p9 = val[15:0];
      esc_pkg::REG_HUM_CALIB:        cal_hum = val;
      default: ;
    endcase
  endtask

  // Drain everything in flight, then hold a little longer
  task automatic drain();
    start <= 1'b0;
    wait (readings_due.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic load_cal(int k);
    write_reg(esc_pkg::REG_TEMP_CALIB, cal_sets[k][0]);
    write_reg(esc_pkg::REG_PRESS_CALIB_LO, cal_sets[k][1]);
    write_reg(esc_pkg::REG_PRESS_CALIB_HI, cal_sets[k][2]);
    write_reg(esc_pkg::REG_PRESS_CALIB_LAST, cal_sets[k][3]);
    write_reg(esc_pkg::REG_HUM_CALIB, cal_sets[k][4]);
    // unmapped index: must leave every word alone
    write_reg(REG_UNMAPPED, {$urandom, $urandom});
  endtask

  // Send one input beat; start stays high across back-to-back beats
  task automatic send(esc_pkg::sample_t s, logic chk, esc_pkg::result_t want);
    note_t n;
    // draw again before each idle cycle so the idle share matches the percentage
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    n.chk = chk;
    n.want = want;
    row_notes.push_back(n);
    start <= 1'b1;
    sample <= s;
    do @(posedge clk); while (busy);
  endtask

  function automatic esc_pkg::sample_t rand_sample();
    esc_pkg::sample_t s;
    if ($urandom_range(99) < 70) begin
      // realistic readings around room conditions
      s.raw_temperature = 20'($urandom_range(560000, 470000));
      s.raw_pressure = 20'($urandom_range(500000, 250000));
      s.raw_humidity = 16'($urandom_range(40000, 20000));
    end else begin
      s.raw_temperature = 20'($urandom);
      s.raw_pressure = 20'($urandom);
      s.raw_humidity = 16'($urandom);
    end
    return s;
  endfunction

  initial begin
    int n_per;
    stim_row_t row;

    cal_temp = '0; cal_plo = '0; cal_phi = '0; cal_p9 = '0; cal_hum = '0;

    // Calibration sets: reset, typical part, all ones, positive and
    // negative extremes, tiny P1 divisor, then two random sets
    cal_sets[0] = '{64'h0, 64'h0, 64'h0, 64'h0, 64'h0};
    cal_sets[1] = '{64'({16'hFC18, 16'd26435, 16'd27504}),
                    {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                    {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                    64'd6000,
                    {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75}};
    cal_sets[2] = '{64'({48{1'b1}}), '1, '1, 64'hFFFF, '1};
    cal_sets[3] = '{64'({16'h7FFF, 16'h7FFF, 16'hFFFF}), {{3{16'h7FFF}}, 16'hFFFF},
                    {4{16'h7FFF}}, 64'h7FFF,
                    {8'h7F, 12'h7FF, 12'h7FF, 8'hFF, 16'h7FFF, 8'hFF}};
    cal_sets[4] = '{64'({16'h8000, 16'h8000, 16'h0}), {{3{16'h8000}}, 16'h0001},
                    {4{16'h8000}}, 64'h8000,
                    {8'h80, 12'h800, 12'h800, 8'h00, 16'h8000, 8'h00}};
    cal_sets[5] = '{64'({16'hFC18, 16'd26435, 16'd27504}), {48'h0, 16'd1},
                    64'h0, 64'h0, {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd0}};
    for (int k = 6; k < N_CAL; k++)
      for (int j = 0; j < 5; j++)
        cal_sets[k][j] = {$urandom, $urandom};

    // Directed rows: field extremes; with all calibration words at reset
    // every output reads zero and the pressure divisor term is zero
    foreach (dir_rows[i]) ;
    for (int i = 0; i < 16; i++) begin
      row.smp.raw_temperature = i[0] ? 20'hFFFFF : 20'h0;
      row.smp.raw_pressure    = i[1] ? 20'hFFFFF : 20'h0;
      row.smp.raw_humidity    = i[2] ? 16'hFFFF : 16'h0;
      if (i[3]) row.smp = '{20'h55555, 20'hAAAAA, 16'h5555};
      row.chk = 1'b1;
      row.want = '0;
      dir_rows.push_back(row);
    end
    row.smp = '{20'd519888, 20'd415148, 16'd30000};
    dir_rows.push_back(row);
    row.smp = '{20'hAAAAA, 20'h55555, 16'hAAAA};
    dir_rows.push_back(row);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset calibration: typed expectations, back to back
    foreach (dir_rows[i]) send(dir_rows[i].smp, dir_rows[i].chk, dir_rows[i].want);
    drain();

    // Same rows under each special calibration, checked by the predictor
    for (int k = 1; k < 6; k++) begin
      load_cal(k);
      foreach (dir_rows[i]) send(dir_rows[i].smp, 1'b0, '0);
      drain();
    end

    // Random part: sender idles 15%, then 81%, then never
    n_per = N_RAND / N_CAL;
    for (int k = 0; k < N_CAL; k++) begin
      load_cal((k + 1) % N_CAL);
      for (int i = 0; i < n_per; i++) begin
        if (k < 3) sender_idle_pct = 15;
        else if (k < 6) sender_idle_pct = 81;
        else sender_idle_pct = 0;
        send(rand_sample(), 1'b0, '0);
      end
      // hold off once mid-run until every result is back
      if (k == 4) begin
        start <= 1'b0;
        wait (readings_due.size() == 0);
      end
      drain();
    end

    start <= 1'b0;
    wait (readings_due.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (fails == 0 && readings_due.size() == 0)
      $display("[env_sensor_compensation] OK");
    else
      $display("[env_sensor_compensation] ERROR");
    $finish;
  end

endmodule
